>>> rtl/ieepm_pkg.sv
// Package for the paged EEPROM bus master: phase codes, status codes, actions.
// No dependencies.
`timescale 1ns / 1ps
package ieepm_pkg;
  localparam int unsigned PAGE_BYTES  = 256;
  localparam int unsigned PAGE_W      = $clog2(PAGE_BYTES);
  localparam logic [18:0] ADDRESS_MAX = 19'h7FFFF;
  localparam logic [15:0] WCT_RESET   = 16'd1000;
  localparam logic [18:0] WAL_RESET   = 19'd524255;
  localparam logic [7:0]  CTRL_WR     = 8'hA0;
  localparam logic [7:0]  CTRL_RD     = 8'hA1;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_DATA  = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    REG_WCT = 1'b0,
    REG_WAL = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ADDR = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_NAK_HIGH = 3'd3,
    ST_NAK_LOW  = 3'd4,
    ST_NAK_DATA = 3'd5,
    ST_NAK_RCTL = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_CTRL, PH_HIGH, PH_LOW, PH_FETCH, PH_DATA,
    PH_RSTART, PH_RCTRL, PH_RX, PH_STOP, PH_WAIT
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [18:0] address;
    logic [18:0] length;
    logic [7:0]  data_byte;
    logic        sda_in;
  } word_in_t;

  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        wp_on;
    logic        busy_res;
    logic        need_byte;
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        rd_last;
    logic        done_res;
    logic [2:0]  status;
  } word_out_t;
endpackage

>>> rtl/ieepm_fifo.sv
// Two-entry word queue between the command front and the bus engine.
// Depends on ieepm_pkg.
`timescale 1ns / 1ps
module ieepm_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  ieepm_pkg::word_in_t wr_word,
  output logic                rd_valid,
  input  logic                rd_ready,
  output ieepm_pkg::word_in_t rd_word
);
  ieepm_pkg::word_in_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_word  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/ieepm_engine.sv
// Bus engine: runs one word per cycle through the phase machine unless out_ready stalls it, registered result.
// Depends on ieepm_pkg.
`timescale 1ns / 1ps
module ieepm_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ieepm_pkg::word_in_t  in_word,
  input  logic [15:0]          wct,
  input  logic [18:0]          wal,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ieepm_pkg::word_out_t out_word
);
  localparam int unsigned PW = ieepm_pkg::PAGE_W;

  ieepm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [18:0] addr_r, addr_nxt, tot_r, tot_nxt;
  logic [PW:0] pg_r, pg_nxt;
  logic [8:0]  pend_r, pend_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        rd_r, rd_nxt, scl_r, scl_nxt, sda_r, sda_nxt, wp_r, wp_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        ov_r;
  ieepm_pkg::word_out_t ow_r, ow_nxt;

  logic        go;
  logic [18:0] alim;
  logic [PW:0] room;
  logic [18:0] room_w;
  logic        tx_busy, tx_ok, tx_nak;
  logic [18:0] addr_inc;

  assign in_ready  = !ov_r || out_ready;
  assign go        = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_word  = ow_r;

  assign room     = (PW+1)'(ieepm_pkg::PAGE_BYTES) - {1'b0, addr_r[PW-1:0]};
  assign room_w   = 19'(room);
  assign addr_inc = (addr_r >= ieepm_pkg::ADDRESS_MAX) ? 19'd0 : addr_r + 19'd1;

  // Shared byte transmit step: low half drives a bit, high half counts or samples ACK.
  always_comb begin
    tx_busy = 1'b1;
    tx_ok   = 1'b0;
    tx_nak  = 1'b0;
    if (!scl_r) begin
      if (bit_r >= 4'd8) begin
        tx_busy = 1'b0;
        tx_ok   = !in_word.sda_in;
        tx_nak  = in_word.sda_in;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r; bit_nxt = bit_r; sh_nxt = sh_r; addr_nxt = addr_r;
    tot_nxt = tot_r; pg_nxt = pg_r; pend_nxt = pend_r; wait_nxt = wait_r;
    rd_nxt = rd_r; scl_nxt = scl_r; sda_nxt = sda_r; wp_nxt = wp_r; err_nxt = err_r;
    ow_nxt = '0;
    alim = (in_word.action == ieepm_pkg::ACT_WRITE) ? wal : ieepm_pkg::ADDRESS_MAX;
    unique case (ieepm_pkg::action_t'(in_word.action))
      ieepm_pkg::ACT_WRITE, ieepm_pkg::ACT_READ: begin
        if (phase_r == ieepm_pkg::PH_IDLE) begin
          priority if (in_word.address > alim) begin
            ow_nxt.done_res = 1'b1; ow_nxt.status = ieepm_pkg::ST_BAD_ADDR;
          end else if (in_word.length == 19'd0 || in_word.length > alim) begin
            ow_nxt.done_res = 1'b1; ow_nxt.status = ieepm_pkg::ST_BAD_LEN;
          end else begin
            rd_nxt   = (in_word.action == ieepm_pkg::ACT_READ);
            addr_nxt = in_word.address;
            tot_nxt  = in_word.length;
            pend_nxt = '0;
            err_nxt  = ieepm_pkg::ST_OK;
            bit_nxt  = '0;
            phase_nxt = ieepm_pkg::PH_START;
            if (in_word.action == ieepm_pkg::ACT_READ) begin
              pg_nxt = '0;
            end else begin
              pg_nxt = (in_word.length < 19'(ieepm_pkg::PAGE_BYTES) -
                        19'(in_word.address[PW-1:0]))
                       ? in_word.length[PW:0]
                       : (PW+1)'(ieepm_pkg::PAGE_BYTES) - {1'b0, in_word.address[PW-1:0]};
              wp_nxt = 1'b0;
            end
          end
        end
      end
      ieepm_pkg::ACT_DATA: begin
        if (phase_r != ieepm_pkg::PH_IDLE && !rd_r && !pend_r[8])
          pend_nxt = {1'b1, in_word.data_byte};
      end
      ieepm_pkg::ACT_TICK: begin
        if (phase_r == ieepm_pkg::PH_CTRL || phase_r == ieepm_pkg::PH_HIGH ||
            phase_r == ieepm_pkg::PH_LOW || phase_r == ieepm_pkg::PH_DATA ||
            phase_r == ieepm_pkg::PH_RCTRL) begin
          if (scl_r) begin
            scl_nxt = 1'b0;
            sda_nxt = (bit_r < 4'd8) ? sh_r[3'(4'd7 - bit_r)] : 1'b1;
          end else begin
            scl_nxt = 1'b1;
            if (tx_busy) bit_nxt = bit_r + 4'd1;
            else bit_nxt = '0;
          end
        end
        unique case (phase_r)
          ieepm_pkg::PH_START, ieepm_pkg::PH_RSTART: begin
            unique case (bit_r)
              4'd0: begin scl_nxt = 1'b0; sda_nxt = 1'b1; bit_nxt = 4'd1; end
              4'd1: begin scl_nxt = 1'b1; bit_nxt = 4'd2; end
              default: begin
                sda_nxt = 1'b0; bit_nxt = '0;
                sh_nxt  = (phase_r == ieepm_pkg::PH_START) ?
                          (ieepm_pkg::CTRL_WR | {4'd0, addr_r[18:16], 1'b0}) :
                          (ieepm_pkg::CTRL_RD | {4'd0, addr_r[18:16], 1'b0});
                phase_nxt = (phase_r == ieepm_pkg::PH_START) ?
                            ieepm_pkg::PH_CTRL : ieepm_pkg::PH_RCTRL;
              end
            endcase
          end
          ieepm_pkg::PH_CTRL: begin
            if (tx_ok) begin sh_nxt = addr_r[15:8]; phase_nxt = ieepm_pkg::PH_HIGH; end
            else if (tx_nak) begin err_nxt = ieepm_pkg::ST_NAK_HIGH;
              phase_nxt = ieepm_pkg::PH_STOP; end
          end
          ieepm_pkg::PH_HIGH: begin
            if (tx_ok) begin sh_nxt = addr_r[7:0]; phase_nxt = ieepm_pkg::PH_LOW; end
            else if (tx_nak) begin err_nxt = ieepm_pkg::ST_NAK_HIGH;
              phase_nxt = ieepm_pkg::PH_STOP; end
          end
          ieepm_pkg::PH_LOW: begin
            if (tx_ok) phase_nxt = rd_r ? ieepm_pkg::PH_RSTART : ieepm_pkg::PH_FETCH;
            else if (tx_nak) begin err_nxt = ieepm_pkg::ST_NAK_LOW;
              phase_nxt = ieepm_pkg::PH_STOP; end
          end
          ieepm_pkg::PH_FETCH: begin
            if (pend_r[8]) begin
              sh_nxt = pend_r[7:0]; pend_nxt = '0; bit_nxt = '0;
              phase_nxt = ieepm_pkg::PH_DATA;
            end
          end
          ieepm_pkg::PH_DATA: begin
            if (tx_ok) begin
              if (pg_r != '0) pg_nxt = pg_r - 1'b1;
              if (tot_r != '0) tot_nxt = tot_r - 19'd1;
              addr_nxt = addr_inc;
              phase_nxt = (pg_r <= (PW+1)'(1)) ? ieepm_pkg::PH_STOP : ieepm_pkg::PH_FETCH;
              if (pg_r <= (PW+1)'(1)) err_nxt = ieepm_pkg::ST_OK;
            end else if (tx_nak) begin
              err_nxt = ieepm_pkg::ST_NAK_DATA; phase_nxt = ieepm_pkg::PH_STOP;
            end
          end
          ieepm_pkg::PH_RCTRL: begin
            if (tx_ok) begin phase_nxt = ieepm_pkg::PH_RX; sh_nxt = '0; end
            else if (tx_nak) begin err_nxt = ieepm_pkg::ST_NAK_RCTL;
              phase_nxt = ieepm_pkg::PH_STOP; end
          end
          ieepm_pkg::PH_RX: begin
            if (scl_r) begin
              scl_nxt = 1'b0;
              sda_nxt = (bit_r < 4'd8) ? 1'b1 : (tot_r == '0);
            end else begin
              scl_nxt = 1'b1;
              if (bit_r < 4'd8) begin
                sh_nxt  = {sh_r[6:0], in_word.sda_in};
                bit_nxt = bit_r + 4'd1;
                if (bit_r == 4'd7) begin
                  ow_nxt.rd_valid = 1'b1;
                  ow_nxt.rd_byte  = {sh_r[6:0], in_word.sda_in};
                  ow_nxt.rd_last  = (tot_r == 19'd1);
                  if (tot_r != '0) tot_nxt = tot_r - 19'd1;
                  addr_nxt = addr_inc;
                end
              end else begin
                bit_nxt = '0; sh_nxt = '0;
                if (tot_r == '0) begin err_nxt = ieepm_pkg::ST_OK;
                  phase_nxt = ieepm_pkg::PH_STOP; end
              end
            end
          end
          ieepm_pkg::PH_STOP: begin
            unique case (bit_r)
              4'd0: begin scl_nxt = 1'b0; sda_nxt = 1'b0; bit_nxt = 4'd1; end
              4'd1: begin scl_nxt = 1'b1; bit_nxt = 4'd2; end
              default: begin
                sda_nxt = 1'b1; bit_nxt = '0; wp_nxt = 1'b1;
                if (err_r != ieepm_pkg::ST_OK || rd_r) begin
                  ow_nxt.done_res = 1'b1; ow_nxt.status = err_r;
                  phase_nxt = ieepm_pkg::PH_IDLE; pend_nxt = '0;
                end else begin
                  wait_nxt = wct; phase_nxt = ieepm_pkg::PH_WAIT;
                end
              end
            endcase
          end
          ieepm_pkg::PH_WAIT: begin
            if (wait_r != '0) begin
              wait_nxt = wait_r - 16'd1;
            end else if (tot_r == '0) begin
              ow_nxt.done_res = 1'b1; ow_nxt.status = ieepm_pkg::ST_OK;
              phase_nxt = ieepm_pkg::PH_IDLE; pend_nxt = '0;
            end else begin
              pg_nxt = (tot_r < room_w) ? tot_r[PW:0] : room;
              wp_nxt = 1'b0; phase_nxt = ieepm_pkg::PH_START; bit_nxt = '0;
            end
          end
          default: phase_nxt = ieepm_pkg::PH_IDLE;
        endcase
      end
      default: ;
    endcase
    // Go to STOP always restarts its bit count.
    if (phase_nxt == ieepm_pkg::PH_STOP && phase_r != ieepm_pkg::PH_STOP) bit_nxt = '0;
    if ((phase_nxt == ieepm_pkg::PH_RSTART || phase_nxt == ieepm_pkg::PH_FETCH ||
         phase_nxt == ieepm_pkg::PH_RX) && phase_nxt != phase_r) bit_nxt = '0;
    ow_nxt.scl       = scl_nxt;
    ow_nxt.sda_out   = sda_nxt;
    ow_nxt.wp_on     = wp_nxt;
    ow_nxt.busy_res  = (phase_nxt != ieepm_pkg::PH_IDLE);
    ow_nxt.need_byte = (phase_nxt == ieepm_pkg::PH_FETCH) && !pend_nxt[8];
  end

  always_ff @(posedge clk) begin
    if (go) ow_r <= ow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ieepm_pkg::PH_IDLE; bit_r <= '0; sh_r <= '0; addr_r <= '0;
      tot_r <= '0; pg_r <= '0; pend_r <= '0; wait_r <= '0; rd_r <= 1'b0;
      scl_r <= 1'b1; sda_r <= 1'b1; wp_r <= 1'b1; err_r <= '0; ov_r <= 1'b0;
    end else begin
      if (go) begin
        phase_r <= phase_nxt; bit_r <= bit_nxt; sh_r <= sh_nxt; addr_r <= addr_nxt;
        tot_r <= tot_nxt; pg_r <= pg_nxt; pend_r <= pend_nxt; wait_r <= wait_nxt;
        rd_r <= rd_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt; wp_r <= wp_nxt;
        err_r <= err_nxt;
      end
      if (go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end
endmodule

>>> rtl/i2c_eeprom_page_access_master_top.sv
// Top level of the paged EEPROM bus master: config registers, word queue, engine.
// Depends on ieepm_pkg, ieepm_fifo, ieepm_engine.
`timescale 1ns / 1ps
// Usage:
//  The in_ channel carries one word per step: a tick (one SCL half-period),
//  a write or read command, or a write data byte. Every accepted word yields
//  exactly one out_ word with the line levels, busy/need_byte flags, any
//  received byte and, on completion, done_res with status.
//  The cfg_ channel writes write_cycle_ticks (index 0) and write_address_limit
//  (index 1); write only while the block is idle.
//  A two-entry queue decouples the input side from the bus engine; the engine
//  retires one word per cycle while out_ready is high, so throughput is one
//  word per cycle; a word passes through a queue entry, then the result register.
//  The engine's result register holds while out_ready is low; the queue then
//  fills and in_ready drops after two more words.
//  Reset (synchronous, rst_n low) returns the engine to idle with SCL, SDA
//  and WP high and both registers at their defaults.
module i2c_eeprom_page_access_master_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [18:0] in_address,
  input  logic [18:0] in_length,
  input  logic [7:0]  in_data_byte,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl,
  output logic        out_sda_out,
  output logic        out_wp_on,
  output logic        out_busy_res,
  output logic        out_need_byte,
  output logic        out_rd_valid,
  output logic [7:0]  out_rd_byte,
  output logic        out_rd_last,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [18:0] cfg_data
);
  logic [15:0] wct_r;
  logic [18:0] wal_r;
  ieepm_pkg::word_in_t  in_w, q_w;
  ieepm_pkg::word_out_t o_w;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wct_r <= ieepm_pkg::WCT_RESET;
      wal_r <= ieepm_pkg::WAL_RESET;
    end else if (cfg_valid) begin
      unique case (ieepm_pkg::reg_idx_t'(cfg_index))
        ieepm_pkg::REG_WCT: wct_r <= cfg_data[15:0];
        ieepm_pkg::REG_WAL: wal_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_w = '{action: in_action, address: in_address, length: in_length,
                  data_byte: in_data_byte, sda_in: in_sda_in};

  ieepm_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_word(in_w),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_w)
  );

  ieepm_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q_valid), .in_ready(q_ready), .in_word(q_w),
    .wct(wct_r), .wal(wal_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(o_w)
  );

  assign out_scl       = o_w.scl;
  assign out_sda_out   = o_w.sda_out;
  assign out_wp_on     = o_w.wp_on;
  assign out_busy_res  = o_w.busy_res;
  assign out_need_byte = o_w.need_byte;
  assign out_rd_valid  = o_w.rd_valid;
  assign out_rd_byte   = o_w.rd_byte;
  assign out_rd_last   = o_w.rd_last;
  assign out_done_res  = o_w.done_res;
  assign out_status    = o_w.status;

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ieepm_pkg::ST_OK)
    else $error("status set without done");
  a_rd_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rd_last |-> out_rd_valid)
    else $error("rd_last without rd_valid");
  a_need_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_need_byte |-> out_busy_res && !out_wp_on)
    else $error("need_byte while idle or protected");
endmodule
